FILE: sv/ljap_pkg.sv
// Shared types, constants and helper functions for the Lennard-Jones all-pairs force block.
// Depends on nothing; imported by lennard_jones_all_pairs_forces.
`timescale 1ns / 1ps

package ljap_pkg;

    // Sequencer states of the pair engine.
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CSQ,
        ST_RCP,
        ST_RDIV,
        ST_RFIN,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P6,
        ST_P7,
        ST_PEND,
        ST_ESUB,
        ST_EDIV,
        ST_FLD,
        ST_FMUL,
        ST_EACC,
        ST_ROWI,
        ST_ROWW,
        ST_PAIR,
        ST_DLD,
        ST_DSTART,
        ST_DDIV,
        ST_DFIN,
        ST_DSQ,
        ST_CMP,
        ST_NEXTJ,
        ST_ROWEND,
        ST_EMRD,
        ST_EMLD,
        ST_EMW
    } ljap_state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_BOX_LENGTH    = 2'd0;
    localparam logic [1:0] REG_CUTOFF_RADIUS = 2'd1;

    // Saturation limits.
    localparam logic [63:0]        QSAT    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SSAT    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [47:0] F48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] F48_MIN = 48'sh8000_0000_0000;
    // Largest magnitudes that still scale by 48 and by 4 without saturating.
    localparam logic signed [63:0] F_LIM   = 64'sd192153584101141162;
    localparam logic signed [63:0] E_LIM   = 64'sd2305843009213693951;

    // Takes a full 128-bit product, drops 32 fraction bits and caps the result.
    // Returns {saturated, value}.
    function automatic logic [64:0] mulq_cap(input logic [127:0] p, input logic [63:0] cap);
        logic       sat;
        logic [63:0] v;
        begin
            sat = (p[127:96] != 32'd0) || (p[95:32] > cap);
            v   = sat ? cap : p[95:32];
            return {sat, v};
        end
    endfunction

    // Saturating 48-bit signed add. Returns {saturated, value}.
    function automatic logic [48:0] sat_add48(input logic signed [47:0] a,
                                              input logic signed [47:0] b);
        logic signed [48:0] s;
        begin
            s = 49'(a) + 49'(b);
            if (s > 49'(F48_MAX)) begin
                return {1'b1, F48_MAX};
            end else if (s < 49'(F48_MIN)) begin
                return {1'b1, F48_MIN};
            end
            return {1'b0, s[47:0]};
        end
    endfunction

endpackage

FILE: sv/lennard_jones_all_pairs_forces.sv
// Lennard-Jones all-pairs force engine with minimum-image wrapping in a periodic cubic box.
// Depends on ljap_pkg (state type, limits, saturating helpers).
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  s_tdata: pos_x, pos_y, pos_z; s_tlast: last_particle
//   m_        out        m_tvalid/m_tready  m_tdata: index, forces, energy; m_tuser; m_tlast
//   cfg_      in         cfg_valid/ready    cfg_index, cfg_data (box_length, cutoff_radius)
//
// Position beats are taken one per cycle while loading. The beat with tlast starts the pair
// sweep: a setup pass that squares the cutoff and forms the cutoff energy, then for every
// ordered pair the minimum-image distance and, inside the cutoff, the force and energy terms.
// The sweep runs on the restoring divider (one quotient bit per cycle) and the shared 32x32
// multiplier. Results then leave one beat per particle, each held until m_tready takes it.
// aresetn is synchronous; no memory clearing pass is needed since every row read was written.
`timescale 1ns / 1ps

module lennard_jones_all_pairs_forces
    import ljap_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Position input beats.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic         s_tlast,   // last_particle
    // Force results.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // particle_index [5:0], force_x [53:6], force_y [101:54],
                                    // force_z [149:102], total_energy [197:150], zeros above
    output logic [0:0]   m_tuser,   // overflowed
    output logic         m_tlast,   // last_result
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    ljap_state_t state_reg, state_next;

    // Configuration and set bookkeeping.
    logic [30:0]   box_reg, cut_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;

    // Position store (one row per particle) and per-particle force store.
    logic [95:0]   pos_mem [MAX_PARTICLES];
    logic [95:0]   pos_rd_reg;
    logic [IW-1:0] pos_raddr;
    logic [143:0]  frc_mem [MAX_PARTICLES];
    logic [143:0]  frc_rd_reg;

    // Loop counters and pair operands.
    logic [IW-1:0] i_reg, j_reg, last_idx;
    logic [1:0]    k_reg;
    logic [95:0]   pi_reg, pj_reg;
    logic signed [31:0] d0_reg, d1_reg, d2_reg;
    logic [63:0]   r2_reg, rc2_reg, rr_reg;
    logic          cutrun_reg, powsat_reg, rcsat_reg, dneg_reg;

    // Inverse-distance powers, Q32.32.
    logic [63:0]   s_reg, s2_reg, s3_reg, s4_reg, s6_reg, s7_reg;
    logic signed [63:0] f_reg, e_reg, ec_reg;
    logic signed [47:0] eq_reg, facc0_reg, facc1_reg, facc2_reg, eacc_reg;

    // Shared multiplier: four 32x32 partial products accumulated into 128 bits.
    logic [63:0]   mul_a_reg, mul_b_reg, prod_reg;
    logic [1:0]    mph_reg;
    logic [2:0]    mul_cnt_reg;
    logic [127:0]  macc_reg;
    logic          mul_run, mul_done;
    logic [31:0]   mul_pa, mul_pb;
    logic [63:0]   mul_p;
    logic [127:0]  mul_sh;

    // Shared restoring divider.
    logic [64:0]   dq_reg;
    logic [63:0]   rem_reg, dvs_reg;
    logic [6:0]    div_cnt_reg;
    logic          div_run;
    logic [64:0]   div_rt, div_df;
    logic          div_ge;

    // Output register.
    logic          m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [199:0]  m_tdata_reg;

    logic          s_acc, m_acc, cfg_acc;
    logic [30:0]   len;

    // Working values of the individual steps.
    logic [31:0]   pic, pjc;
    logic signed [32:0] diff;
    logic [32:0]   dabs;
    logic [30:0]   remv, dmag;
    logic [31:0]   rem2;
    logic          up;
    logic signed [31:0] dval;
    logic [64:0]   mq_q, mq_f;
    logic signed [63:0] fv, ev, fsc, esc, fmag;
    logic          fsat, esat;
    logic signed [64:0] sd;
    logic signed [63:0] sdc;
    logic          sdsat;
    logic signed [63:0] eadj;
    logic [31:0]   d0abs;
    logic signed [47:0] term;
    logic [48:0]   fadd, eadd;
    logic signed [47:0] hsum;

    assign s_acc    = s_tvalid & s_tready;
    assign m_acc    = m_tvalid_reg & m_tready;
    assign cfg_acc  = cfg_valid & cfg_ready;
    assign cfg_ready = 1'b1;
    assign len      = (box_reg == 31'd0) ? 31'd1 : box_reg;
    assign last_idx = IW'(cnt_reg - CW'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- Next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (s_acc && s_tlast) state_next = ST_CSQ;
            ST_CSQ:    if (mul_done) state_next = ST_RCP;
            ST_RCP:    state_next = (rr_reg <= 64'd2) ? ST_PEND : ST_RDIV;
            ST_RDIV:   if (div_cnt_reg == 7'd1) state_next = ST_RFIN;
            ST_RFIN:   state_next = ST_P2;
            ST_P2:     if (mul_done) state_next = ST_P3;
            ST_P3:     if (mul_done) state_next = ST_P4;
            ST_P4:     if (mul_done) state_next = ST_P6;
            ST_P6:     if (mul_done) state_next = ST_P7;
            ST_P7:     if (mul_done) state_next = ST_PEND;
            ST_PEND: begin
                if (cutrun_reg)      state_next = ST_ROWI;
                else if (powsat_reg) state_next = ST_FLD;
                else                 state_next = ST_ESUB;
            end
            ST_ESUB:   state_next = ST_EDIV;
            ST_EDIV:   state_next = ST_FLD;
            ST_FLD:    state_next = ST_FMUL;
            ST_FMUL:   if (mul_done) state_next = (k_reg == 2'd2) ? ST_EACC : ST_FLD;
            ST_EACC:   state_next = ST_NEXTJ;
            ST_ROWI:   state_next = ST_ROWW;
            ST_ROWW:   state_next = ST_PAIR;
            ST_PAIR:   state_next = (j_reg == i_reg) ? ST_NEXTJ : ST_DLD;
            ST_DLD:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DDIV;
            ST_DDIV:   if (div_cnt_reg == 7'd1) state_next = ST_DFIN;
            ST_DFIN:   state_next = ST_DSQ;
            ST_DSQ:    if (mul_done) state_next = (k_reg == 2'd2) ? ST_CMP : ST_DSTART;
            ST_CMP:    state_next = (r2_reg >= rc2_reg) ? ST_NEXTJ : ST_RCP;
            ST_NEXTJ:  state_next = (j_reg == last_idx) ? ST_ROWEND : ST_PAIR;
            ST_ROWEND: state_next = (i_reg == last_idx) ? ST_EMRD : ST_ROWI;
            ST_EMRD:   state_next = ST_EMLD;
            ST_EMLD:   state_next = ST_EMW;
            ST_EMW:    if (m_acc) state_next = m_tlast_reg ? ST_LOAD : ST_EMRD;
            default:   state_next = ST_LOAD;
        endcase
    end

    // ---------------- State decodes ----------------
    always_comb begin
        s_tready  = 1'b0;
        mul_run   = 1'b0;
        div_run   = 1'b0;
        pos_raddr = j_reg;
        unique case (state_reg)
            ST_LOAD: s_tready = 1'b1;
            ST_CSQ, ST_DSQ, ST_P2, ST_P3, ST_P4, ST_P6, ST_P7, ST_FMUL: mul_run = 1'b1;
            ST_DDIV, ST_RDIV: div_run = 1'b1;
            ST_ROWI: pos_raddr = i_reg;
            default: ;
        endcase
    end

    // ---------------- Arithmetic helpers ----------------
    always_comb begin
        mul_pa   = mul_cnt_reg[0] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        mul_pb   = mul_cnt_reg[1] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        mul_p    = mul_pa * mul_pb;
        mul_done = mul_run && (mul_cnt_reg == 3'd5);
        case (mph_reg)
            2'd0:    mul_sh = {64'd0, prod_reg};
            2'd3:    mul_sh = {prod_reg, 64'd0};
            default: mul_sh = {32'd0, prod_reg, 32'd0};
        endcase

        div_rt = {rem_reg, dq_reg[64]};
        div_df = div_rt - {1'b0, dvs_reg};
        div_ge = div_rt >= {1'b0, dvs_reg};

        mq_q = mulq_cap(macc_reg, QSAT);
        mq_f = mulq_cap(macc_reg, {16'd0, F48_MAX});

        // Coordinate difference for the current dimension.
        case (k_reg)
            2'd0:    begin pic = pi_reg[31:0];  pjc = pj_reg[31:0];  end
            2'd1:    begin pic = pi_reg[63:32]; pjc = pj_reg[63:32]; end
            default: begin pic = pi_reg[95:64]; pjc = pj_reg[95:64]; end
        endcase
        diff = {pic[31], pic} - {pjc[31], pjc};
        dabs = diff[32] ? 33'(-diff) : 33'(diff);

        // Round to the nearest box multiple, ties to the even multiple.
        remv = rem_reg[30:0];
        rem2 = {remv, 1'b0};
        up   = (rem2 > {1'b0, len}) || ((rem2 == {1'b0, len}) && dq_reg[0]);
        dmag = up ? (len - remv) : remv;
        dval = (dneg_reg ^ up) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

        // Force scalar and pair energy, both scaled with saturation.
        fv   = $signed(s7_reg) - $signed({1'b0, s4_reg[63:1]});
        ev   = $signed(s6_reg) - $signed(s3_reg);
        fsat = (fv > F_LIM) || (fv < -F_LIM);
        esat = (ev > E_LIM) || (ev < -E_LIM);
        fsc  = fsat ? (fv[63] ? -SSAT : SSAT) : ((fv <<< 5) + (fv <<< 4));
        esc  = esat ? (ev[63] ? -SSAT : SSAT) : (ev <<< 2);

        // Pair energy minus cutoff energy, clamped.
        sd    = 65'(e_reg) - 65'(ec_reg);
        sdsat = (sd > 65'(SSAT)) || (sd < -65'(SSAT));
        sdc   = sdsat ? (sd[64] ? -SSAT : SSAT) : sd[63:0];
        eadj  = e_reg + (e_reg[63] ? 64'sd65535 : 64'sd0);

        fmag  = f_reg[63] ? -f_reg : f_reg;
        d0abs = d0_reg[31] ? 32'(-d0_reg) : 32'(d0_reg);
        term  = (f_reg[63] ^ d0_reg[31]) ? -$signed(mq_f[47:0]) : $signed(mq_f[47:0]);
        fadd  = sat_add48(facc0_reg, term);
        eadd  = sat_add48(eacc_reg, eq_reg);
        hsum  = eacc_reg + 48'(eacc_reg[47]);
    end

    // ---------------- Memories ----------------
    always_ff @(posedge aclk) begin
        if (s_acc && (cnt_reg < CW'(MAX_PARTICLES))) begin
            pos_mem[cnt_reg[IW-1:0]] <= s_tdata;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROWEND) begin
            frc_mem[i_reg] <= {facc2_reg, facc1_reg, facc0_reg};
        end
        frc_rd_reg <= frc_mem[i_reg];
    end

    // ---------------- Shared units ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_cnt_reg <= 3'd0;
        end else if (!mul_run || mul_done) begin
            mul_cnt_reg <= 3'd0;
        end else begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
        end
        if (!mul_run || mul_done) begin
            macc_reg <= 128'd0;
        end else begin
            if (mul_cnt_reg < 3'd4) begin
                prod_reg <= mul_p;
                mph_reg  <= mul_cnt_reg[1:0];
            end
            if (mul_cnt_reg != 3'd0) begin
                macc_reg <= macc_reg + mul_sh;
            end
        end
    end

    // ---------------- Sequencer and datapath ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            box_reg      <= 31'd655360;
            cut_reg      <= 31'd163840;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            eacc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            div_cnt_reg  <= 7'd0;
        end else begin
            state_reg <= state_next;

            if (cfg_acc) begin
                unique case (cfg_index)
                    REG_BOX_LENGTH:    box_reg <= cfg_data;
                    REG_CUTOFF_RADIUS: cut_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (div_run) begin
                rem_reg     <= div_ge ? div_df[63:0] : div_rt[63:0];
                dq_reg      <= {dq_reg[63:0], div_ge};
                div_cnt_reg <= div_cnt_reg - 7'd1;
            end

            if (m_acc) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (cnt_reg < CW'(MAX_PARTICLES)) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    mul_a_reg <= {33'd0, cut_reg};
                    mul_b_reg <= {33'd0, cut_reg};
                end
                ST_CSQ: begin
                    if (mul_done) begin
                        rc2_reg    <= macc_reg[63:0];
                        rr_reg     <= macc_reg[63:0];
                        cutrun_reg <= 1'b1;
                    end
                end
                ST_RCP: begin
                    powsat_reg  <= (rr_reg <= 64'd2);
                    dq_reg      <= {1'b1, 64'd0};
                    rem_reg     <= 64'd0;
                    dvs_reg     <= rr_reg;
                    div_cnt_reg <= 7'd65;
                end
                ST_RFIN: begin
                    s_reg     <= dq_reg[63:0];
                    mul_a_reg <= dq_reg[63:0];
                    mul_b_reg <= dq_reg[63:0];
                end
                ST_P2: begin
                    if (mul_done) begin
                        s2_reg     <= mq_q[63:0];
                        powsat_reg <= powsat_reg | mq_q[64];
                        mul_a_reg  <= mq_q[63:0];
                        mul_b_reg  <= s_reg;
                    end
                end
                ST_P3: begin
                    if (mul_done) begin
                        s3_reg     <= mq_q[63:0];
                        powsat_reg <= powsat_reg | mq_q[64];
                        mul_a_reg  <= s2_reg;
                        mul_b_reg  <= s2_reg;
                    end
                end
                ST_P4: begin
                    if (mul_done) begin
                        s4_reg     <= mq_q[63:0];
                        powsat_reg <= powsat_reg | mq_q[64];
                        mul_a_reg  <= s3_reg;
                        mul_b_reg  <= s3_reg;
                    end
                end
                ST_P6: begin
                    if (mul_done) begin
                        s6_reg     <= mq_q[63:0];
                        powsat_reg <= powsat_reg | mq_q[64];
                        mul_a_reg  <= mq_q[63:0];
                        mul_b_reg  <= s_reg;
                    end
                end
                ST_P7: begin
                    if (mul_done) begin
                        s7_reg     <= mq_q[63:0];
                        powsat_reg <= powsat_reg | mq_q[64];
                    end
                end
                ST_PEND: begin
                    k_reg <= 2'd0;
                    if (cutrun_reg) begin
                        // Cutoff terms are kept for the whole set; their flags count per pair.
                        ec_reg    <= esc;
                        rcsat_reg <= fsat | esat;
                        i_reg     <= '0;
                    end else if (powsat_reg) begin
                        ovf_reg <= 1'b1;
                        f_reg   <= SSAT;
                        eq_reg  <= F48_MAX;
                    end else begin
                        ovf_reg <= ovf_reg | fsat | esat | rcsat_reg;
                        f_reg   <= fsc;
                        e_reg   <= esc;
                    end
                end
                ST_ESUB: begin
                    e_reg   <= sdc;
                    ovf_reg <= ovf_reg | sdsat;
                end
                ST_EDIV: begin
                    eq_reg <= eadj[63:16];
                end
                ST_FLD: begin
                    mul_a_reg <= fmag;
                    mul_b_reg <= {32'd0, d0abs};
                end
                ST_FMUL: begin
                    if (mul_done) begin
                        ovf_reg   <= ovf_reg | mq_f[64] | fadd[48];
                        facc0_reg <= facc1_reg;
                        facc1_reg <= facc2_reg;
                        facc2_reg <= fadd[47:0];
                        d0_reg    <= d1_reg;
                        d1_reg    <= d2_reg;
                        d2_reg    <= d0_reg;
                        k_reg     <= k_reg + 2'd1;
                    end
                end
                ST_EACC: begin
                    eacc_reg <= eadd[47:0];
                    ovf_reg  <= ovf_reg | eadd[48];
                end
                ST_ROWI: begin
                    j_reg <= '0;
                end
                ST_ROWW: begin
                    pi_reg    <= pos_rd_reg;
                    facc0_reg <= '0;
                    facc1_reg <= '0;
                    facc2_reg <= '0;
                end
                ST_DLD: begin
                    pj_reg <= pos_rd_reg;
                    k_reg  <= 2'd0;
                    r2_reg <= 64'd0;
                end
                ST_DSTART: begin
                    dneg_reg    <= diff[32];
                    dq_reg      <= {dabs, 32'd0};
                    rem_reg     <= 64'd0;
                    dvs_reg     <= {33'd0, len};
                    div_cnt_reg <= 7'd33;
                end
                ST_DFIN: begin
                    d0_reg    <= d1_reg;
                    d1_reg    <= d2_reg;
                    d2_reg    <= dval;
                    mul_a_reg <= {33'd0, dmag};
                    mul_b_reg <= {33'd0, dmag};
                end
                ST_DSQ: begin
                    if (mul_done) begin
                        r2_reg <= r2_reg + macc_reg[63:0];
                        k_reg  <= k_reg + 2'd1;
                    end
                end
                ST_CMP: begin
                    rr_reg     <= r2_reg;
                    cutrun_reg <= 1'b0;
                end
                ST_NEXTJ: begin
                    j_reg <= j_reg + IW'(1);
                end
                ST_ROWEND: begin
                    i_reg <= (i_reg == last_idx) ? '0 : i_reg + IW'(1);
                end
                ST_EMLD: begin
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= ovf_reg;
                    m_tlast_reg  <= (i_reg == last_idx);
                    m_tdata_reg  <= {2'b00,
                                     (i_reg == last_idx) ? {hsum[47], hsum[47:1]} : 48'd0,
                                     frc_rd_reg, 6'(i_reg)};
                end
                ST_EMW: begin
                    if (m_acc) begin
                        if (m_tlast_reg) begin
                            cnt_reg  <= '0;
                            ovf_reg  <= 1'b0;
                            eacc_reg <= '0;
                        end else begin
                            i_reg <= i_reg + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The input side only opens once every result of the previous set has gone.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid_reg)
        else $error("input ready while a result is pending");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_PARTICLES))
        else $error("particle count beyond capacity");

    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast_reg) |=> (s_tready && (cnt_reg == '0) && !ovf_reg))
        else $error("set state not cleared after last result");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        div_run |-> (div_cnt_reg != 7'd0))
        else $error("divider stepping with no bits left");

    a_mul_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> $past(mul_run))
        else $error("multiply finished without running");
`endif

endmodule
